// File: hdl/etl_pkg.sv
// ----------------------------------------------------------------------------
// etl_pkg: shared types and constants for the event log throttle
// per-source entry layout, drop codes, register indexes and repeat test
// ----------------------------------------------------------------------------
package etl_pkg;

	localparam int NUM_SOURCES_DEF = 32;
	localparam int SLOT_W           = 5;
	localparam int HASH_W           = 64;
	localparam int TIME_W           = 63;
	localparam int COUNT_W          = 32;
	localparam int LINES_W          = 8;
	localparam int WINDOW_W         = 40;
	localparam int CFG_IDX_W        = 1;

	localparam logic [LINES_W-1:0]  BURST_LINES_RST   = 8'd8;
	localparam logic [WINDOW_W-1:0] WINDOW_LENGTH_RST = 40'd1000000000;
	localparam logic [COUNT_W-1:0]  COUNT_MAX         = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BURST_LINES   = 1'b0,
		REG_WINDOW_LENGTH = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DROP_NONE   = 2'd0,
		DROP_REPEAT = 2'd1,
		DROP_RATE   = 2'd2
	} drop_reason_t;

	typedef struct packed {
		logic [HASH_W-1:0]  last_hash;
		logic [COUNT_W-1:0] repeat_run;
		logic [TIME_W-1:0]  window_start;
		logic [LINES_W-1:0] window_lines;
		logic [COUNT_W-1:0] suppressed_total;
	} slot_entry_t;

	localparam int NUM_POW10 = 10;
	localparam logic [COUNT_W-1:0] POW10_TBL [NUM_POW10] = '{
		32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
		32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
	};

	// true for 1, 10, 100, ... up to the largest that fits in 32 bits
	function automatic logic is_pow10(input logic [COUNT_W-1:0] n);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < NUM_POW10; i++) begin
			if (n == POW10_TBL[i]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] n);
		return (n == COUNT_MAX) ? n : n + COUNT_W'(1);
	endfunction

endpackage

// File: hdl/event_log_throttle.sv
// ----------------------------------------------------------------------------
// event_log_throttle: per-source log rate limiter with repeat collapsing
// decides per event whether to log, keeps per-source repeat and window state
// ----------------------------------------------------------------------------
//  channel | handshake              | words
//  in      | in_valid / in_stall    | source_slot, event_hash, now_ns
//  out     | out_valid / out_stall  | log_now, drop_reason, repeat_count,
//          |                        | flushed_count
//  config  | write_en               | write_index, write_data
//
// one word per cycle while the output is not stalled; a word is held in the input register,
// where the per-source entry is read, updated and written back, and its result
// is registered into the output register.
// reset clears every entry valid bit, so all sources read as zero state.
// a stalled result holds the output register; the input register still takes
// a word behind it, and words for sources beyond the table leave no result.
module event_log_throttle #(
	parameter int NUM_SOURCES = etl_pkg::NUM_SOURCES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [etl_pkg::SLOT_W-1:0]          source_slot,
	input  logic [etl_pkg::HASH_W-1:0]          event_hash,
	input  logic [etl_pkg::TIME_W-1:0]          now_ns,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                log_now,
	output logic [1:0]                          drop_reason,
	output logic [etl_pkg::COUNT_W-1:0]         repeat_count,
	output logic [etl_pkg::COUNT_W-1:0]         flushed_count,
	input  logic                                write_en,
	input  logic [etl_pkg::CFG_IDX_W-1:0]       write_index,
	input  logic [etl_pkg::WINDOW_W-1:0]        write_data
);
	import etl_pkg::*;

	// the slot field reaches 32 sources at most
	localparam int SLOT_SPAN = 1 << SLOT_W;
	localparam int DEPTH     = (NUM_SOURCES < SLOT_SPAN) ? NUM_SOURCES : SLOT_SPAN;
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [SLOT_W:0] DEPTH_V = (SLOT_W+1)'(DEPTH);

	logic [LINES_W-1:0]  burst_lines_q;
	logic [WINDOW_W-1:0] window_length_q;

	logic                s1_valid_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic [HASH_W-1:0]   hash_s1;
	logic [TIME_W-1:0]   now_s1;

	logic [DEPTH-1:0]    slot_valid_q;
	slot_entry_t         entry_q [DEPTH];

	logic                out_valid_q;
	logic                log_now_q;
	drop_reason_t        drop_reason_q;
	logic [COUNT_W-1:0]  repeat_count_q;
	logic [COUNT_W-1:0]  flushed_count_q;

	logic                in_range;
	logic [IDX_W-1:0]    idx;
	logic                out_free;
	logic                advance;
	logic                process;
	slot_entry_t         ent;
	slot_entry_t         ent_new;
	logic                hit;
	logic [COUNT_W-1:0]  rep;
	logic                collapse;
	logic [TIME_W-1:0]   elapsed;
	logic                rollover;
	logic [LINES_W-1:0]  lines_base;
	logic [COUNT_W-1:0]  sup_base;
	logic                over_budget;
	logic                log_d;
	drop_reason_t        reason_d;
	logic [COUNT_W-1:0]  flushed_d;

	// ---------------- control
	assign in_range = ({1'b0, slot_s1} < DEPTH_V);
	assign idx      = slot_s1[IDX_W-1:0];
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = s1_valid_s1 && (!in_range || out_free);
	assign process  = s1_valid_s1 && in_range && out_free;
	assign in_stall = s1_valid_s1 && !advance;

	// ---------------- entry update
	always_comb begin
		ent = slot_valid_q[idx] ? entry_q[idx] : '0;

		hit      = (ent.last_hash == hash_s1);
		rep      = hit ? sat_inc(ent.repeat_run) : COUNT_W'(1);
		collapse = hit && !is_pow10(rep);

		// no window yet, or time moved forward past the window
		elapsed  = now_s1 - ent.window_start;
		rollover = (ent.window_start == '0) ||
			((now_s1 >= ent.window_start) &&
			 (elapsed > {{(TIME_W-WINDOW_W){1'b0}}, window_length_q}));

		lines_base  = rollover ? '0 : ent.window_lines;
		sup_base    = rollover ? '0 : ent.suppressed_total;
		over_budget = (lines_base >= burst_lines_q);

		ent_new            = ent;
		ent_new.last_hash  = hash_s1;
		ent_new.repeat_run = rep;

		if (collapse) begin
			ent_new.suppressed_total = sat_inc(ent.suppressed_total);
			log_d     = 1'b0;
			reason_d  = DROP_REPEAT;
			flushed_d = '0;
		end else begin
			ent_new.window_start = rollover ? now_s1 : ent.window_start;
			flushed_d            = rollover ? ent.suppressed_total : '0;
			if (over_budget) begin
				ent_new.window_lines     = lines_base;
				ent_new.suppressed_total = sat_inc(sup_base);
				log_d    = 1'b0;
				reason_d = DROP_RATE;
			end else begin
				ent_new.window_lines     = lines_base + LINES_W'(1);
				ent_new.suppressed_total = sup_base;
				log_d    = 1'b1;
				reason_d = DROP_NONE;
			end
		end
	end

	// ---------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_lines_q   <= BURST_LINES_RST;
			window_length_q <= WINDOW_LENGTH_RST;
			s1_valid_s1     <= 1'b0;
			out_valid_q     <= 1'b0;
			slot_valid_q    <= '0;
		end else begin
			if (write_en) begin
				case (cfg_reg_t'(write_index))
					REG_BURST_LINES:   burst_lines_q   <= write_data[LINES_W-1:0];
					REG_WINDOW_LENGTH: window_length_q <= write_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				s1_valid_s1 <= 1'b1;
			end else if (advance) begin
				s1_valid_s1 <= 1'b0;
			end
			if (process) begin
				out_valid_q       <= 1'b1;
				slot_valid_q[idx] <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			slot_s1 <= source_slot;
			hash_s1 <= event_hash;
			now_s1  <= now_ns;
		end
		if (process) begin
			entry_q[idx]    <= ent_new;
			log_now_q       <= log_d;
			drop_reason_q   <= reason_d;
			repeat_count_q  <= rep;
			flushed_count_q <= flushed_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign log_now       = log_now_q;
	assign drop_reason   = drop_reason_q;
	assign repeat_count  = repeat_count_q;
	assign flushed_count = flushed_count_q;

`ifndef ASSERT_OFF
	a_log_matches_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (log_now == (drop_reason == DROP_NONE)))
		else $error("log flag disagrees with drop reason");

	a_repeat_no_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && drop_reason == DROP_REPEAT) |-> (flushed_count == '0))
		else $error("collapsed repeat reported a flush");

	a_repeat_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (repeat_count != '0))
		else $error("repeat count of zero on a result");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked word");

	a_entry_marked: assert property (@(posedge clk) disable iff (!arst_n)
		process |=> (slot_valid_q[$past(idx)] && out_valid_q))
		else $error("updated entry not marked valid");
`endif

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for event_log_throttle
// drives event words in bursts against a stalling receiver, predicts each
// log decision from a local copy of the per-source state and compares every
// result word field by field; register settings change between idle phases
// ----------------------------------------------------------------------------
module testbench;
	import etl_pkg::*;

	localparam int NSRC       = NUM_SOURCES_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int PRINT_CAP  = 40;

	typedef struct packed {
		logic               log_now;
		drop_reason_t       reason;
		logic [COUNT_W-1:0] repeats;
		logic [COUNT_W-1:0] flushed;
	} verdict_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [HASH_W-1:0] hash;
		logic [TIME_W-1:0] stamp;
		logic              typed;
		verdict_t          want;
	} stim_row_t;

	typedef struct packed {
		logic [LINES_W-1:0]  burst;
		logic [WINDOW_W-1:0] window;
	} setting_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_LONG
	} stall_mode_t;

	localparam verdict_t UNTYPED = '{1'b0, DROP_NONE, 32'd0, 32'd0};
	localparam logic [TIME_W-1:0] T_MAX = '1;

	// directed words, default settings (8 lines, 1 s window)
	localparam int NUM_DIRECTED = 20;
	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		// zero hash on a fresh source counts as a repeat of an empty run
		'{5'd0,  64'd0, 63'd100, 1'b1, '{1'b1, DROP_NONE,   32'd1, 32'd0}},
		'{5'd0,  64'd0, 63'd200, 1'b1, '{1'b0, DROP_REPEAT, 32'd2, 32'd0}},
		'{5'd31, '1,    T_MAX,   1'b1, '{1'b1, DROP_NONE,   32'd1, 32'd0}},
		'{5'd31, '1,    T_MAX,   1'b1, '{1'b0, DROP_REPEAT, 32'd2, 32'd0}},
		// time going backwards, no rollover
		'{5'd31, 64'd5, 63'd0,   1'b1, '{1'b1, DROP_NONE,   32'd1, 32'd0}},
		// zero timestamp leaves the source without a window
		'{5'd1,  64'hA, 63'd0,   1'b1, '{1'b1, DROP_NONE,   32'd1, 32'd0}},
		'{5'd1,  64'hB, 63'd5,   1'b0, UNTYPED},
		// fill the line budget of source 2
		'{5'd2,  64'd1, 63'd1000, 1'b0, UNTYPED},
		'{5'd2,  64'd2, 63'd1001, 1'b0, UNTYPED},
		'{5'd2,  64'd1, 63'd1002, 1'b0, UNTYPED},
		'{5'd2,  64'd2, 63'd1003, 1'b0, UNTYPED},
		'{5'd2,  64'd1, 63'd1004, 1'b0, UNTYPED},
		'{5'd2,  64'd2, 63'd1005, 1'b0, UNTYPED},
		'{5'd2,  64'd1, 63'd1006, 1'b0, UNTYPED},
		'{5'd2,  64'd2, 63'd1007, 1'b0, UNTYPED},
		'{5'd2,  64'd1, 63'd1008, 1'b1, '{1'b0, DROP_RATE,   32'd1, 32'd0}},
		// exactly one window later is still the same window
		'{5'd2,  64'd2, 63'd1000001000, 1'b0, UNTYPED},
		'{5'd2,  64'd1, 63'd1000001001, 1'b1, '{1'b1, DROP_NONE, 32'd1, 32'd2}},
		'{5'd3,  64'h8000_0000_0000_0000, 63'h4000_0000_0000_0000, 1'b0, UNTYPED},
		'{5'd3,  64'h8000_0000_0000_0000, 63'h4000_0000_0000_0000, 1'b0, UNTYPED}
	};

	localparam int NUM_SETTINGS = 5;
	localparam setting_t SETTINGS_LIST [NUM_SETTINGS] = '{
		'{8'd1,   40'd1},
		'{8'd255, 40'hFF_FFFF_FFFF},
		'{8'd0,   40'd1000},
		'{8'd3,   40'd50},
		'{8'd8,   40'd1000000000}
	};

	logic clk;
	logic arst_n = 1'b0;

	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic [SLOT_W-1:0]   source_slot = '0;
	logic [HASH_W-1:0]   event_hash  = '0;
	logic [TIME_W-1:0]   now_ns      = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic                log_now;
	logic [1:0]          drop_reason;
	logic [COUNT_W-1:0]  repeat_count;
	logic [COUNT_W-1:0]  flushed_count;
	logic                write_en    = 1'b0;
	logic [CFG_IDX_W-1:0] write_index = '0;
	logic [WINDOW_W-1:0] write_data  = '0;

	event_log_throttle u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.source_slot  (source_slot),
		.event_hash   (event_hash),
		.now_ns       (now_ns),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.log_now      (log_now),
		.drop_reason  (drop_reason),
		.repeat_count (repeat_count),
		.flushed_count(flushed_count),
		.write_en     (write_en),
		.write_index  (write_index),
		.write_data   (write_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// local copy of per-source state and settings
	logic [HASH_W-1:0]   seen_hash  [NSRC];
	logic [COUNT_W-1:0]  run_len    [NSRC];
	logic [TIME_W-1:0]   win_start  [NSRC];
	logic [LINES_W-1:0]  win_lines  [NSRC];
	logic [COUNT_W-1:0]  held_drops [NSRC];
	logic [LINES_W-1:0]  cur_burst;
	logic [WINDOW_W-1:0] cur_window;

	verdict_t pending_verdicts [$];
	int mismatches = 0;

	// stimulus generator state
	int                 burst_left = 0;
	int                 run_left   = 0;
	logic [SLOT_W-1:0]  run_slot;
	logic [HASH_W-1:0]  run_hash;
	logic [TIME_W-1:0]  clock_ns;
	logic [HASH_W-1:0]  hash_pool [4];

	function automatic bit decimal_power(input logic [COUNT_W-1:0] n);
		logic [COUNT_W-1:0] v;
		v = n;
		while (v >= 10 && v % 10 == 0) begin
			v = v / 10;
		end
		return v == 1;
	endfunction

	function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] n);
		return (n == '1) ? n : n + COUNT_W'(1);
	endfunction

	function automatic verdict_t throttle_decide(input logic [SLOT_W-1:0] s,
			input logic [HASH_W-1:0] h, input logic [TIME_W-1:0] t);
		verdict_t v;
		logic same;
		logic [COUNT_W-1:0] rep;
		same = (seen_hash[s] == h);
		if (same) begin
			rep = count_up(run_len[s]);
		end else begin
			seen_hash[s] = h;
			rep = COUNT_W'(1);
		end
		run_len[s] = rep;
		v.repeats = rep;
		v.flushed = '0;
		if (same && !decimal_power(rep)) begin
			held_drops[s] = count_up(held_drops[s]);
			v.log_now = 1'b0;
			v.reason = DROP_REPEAT;
			return v;
		end
		if (win_start[s] == '0 ||
				(t >= win_start[s] && t - win_start[s] > TIME_W'(cur_window))) begin
			win_start[s] = t;
			win_lines[s] = '0;
			v.flushed = held_drops[s];
			held_drops[s] = '0;
		end
		if (win_lines[s] >= cur_burst) begin
			held_drops[s] = count_up(held_drops[s]);
			v.log_now = 1'b0;
			v.reason = DROP_RATE;
		end else begin
			win_lines[s] = win_lines[s] + LINES_W'(1);
			v.log_now = 1'b1;
			v.reason = DROP_NONE;
		end
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	task automatic wait_drained();
		while (pending_verdicts.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [WINDOW_W-1:0] data);
		write_en    <= 1'b1;
		write_index <= idx;
		write_data  <= data;
		@(posedge clk);
		write_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_BURST_LINES:   cur_burst  = data[LINES_W-1:0];
			REG_WINDOW_LENGTH: cur_window = data;
			default: ;
		endcase
	endtask

	task automatic send_event(input logic [SLOT_W-1:0] s, input logic [HASH_W-1:0] h,
			input logic [TIME_W-1:0] t, input logic typed, input verdict_t fixed);
		int gap;
		bit pause;
		verdict_t v;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			pause = ($urandom_range(0, 29) == 0);
			if (pause && gap == 0) begin
				gap = 1;
			end
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				while (pause && pending_verdicts.size() != 0) begin
					@(posedge clk);
				end
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid    <= 1'b1;
		source_slot <= s;
		event_hash  <= h;
		now_ns      <= t;
		do begin
			@(posedge clk);
		end while (in_stall);
		v = throttle_decide(s, h, t);
		pending_verdicts.push_back(typed ? fixed : v);
	endtask

	task automatic start_phase();
		run_left = 0;
		hash_pool[0] = '0;
		hash_pool[1] = '1;
		hash_pool[2] = {$urandom, $urandom};
		hash_pool[3] = {$urandom, $urandom};
		if ($urandom_range(0, 1) == 0) begin
			clock_ns = TIME_W'($urandom_range(1, 1000));
		end else begin
			clock_ns = T_MAX - TIME_W'($urandom) * TIME_W'(64);
		end
	endtask

	// runs of identical events on a few busy sources, with noise words between
	task automatic pick_event(output logic [SLOT_W-1:0] s, output logic [HASH_W-1:0] h,
			output logic [TIME_W-1:0] t);
		int r;
		logic [31:0] step;
		if ($urandom_range(0, 4) == 0) begin
			s = SLOT_W'($urandom_range(0, NSRC - 1));
			h = ($urandom_range(0, 1) == 0) ? hash_pool[$urandom_range(0, 3)]
				: {$urandom, $urandom};
		end else begin
			if (run_left == 0) begin
				r = $urandom_range(0, 99);
				run_slot = ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom_range(0, NSRC - 1))
					: SLOT_W'($urandom_range(0, 3));
				if (r < 50) run_left = 1;
				else if (r < 80) run_left = $urandom_range(2, 12);
				else if (r < 97) run_left = $urandom_range(9, 12);
				else run_left = $urandom_range(99, 102);
				run_hash = ($urandom_range(0, 9) < 7) ? hash_pool[$urandom_range(0, 3)]
					: {$urandom, $urandom};
			end
			run_left--;
			s = run_slot;
			h = run_hash;
		end

		step = ((cur_window >> 4) > 40'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(cur_window >> 4);
		r = $urandom_range(0, 99);
		if (r < 45) clock_ns = clock_ns + TIME_W'($urandom_range(0, step));
		else if (r < 60) ;
		else if (r < 75) clock_ns = clock_ns + TIME_W'(cur_window)
			+ TIME_W'($urandom_range(0, 1));
		else if (r >= 88) clock_ns = clock_ns + TIME_W'($urandom_range(1, 3));
		t = clock_ns;
		if (r >= 75 && r < 82) t = clock_ns - TIME_W'($urandom_range(1, 1000));
		else if (r >= 82 && r < 85) t = '0;
		else if (r >= 85 && r < 88) t = TIME_W'({$urandom, $urandom});
	endtask

	task automatic random_events(input int count);
		logic [SLOT_W-1:0] s;
		logic [HASH_W-1:0] h;
		logic [TIME_W-1:0] t;
		for (int i = 0; i < count; i++) begin
			pick_event(s, h, t);
			send_event(s, h, t, 1'b0, UNTYPED);
		end
	endtask

	initial begin
		for (int i = 0; i < NSRC; i++) begin
			seen_hash[i]  = '0;
			run_len[i]    = '0;
			win_start[i]  = '0;
			win_lines[i]  = '0;
			held_drops[i] = '0;
		end
		cur_burst  = 8'd8;
		cur_window = 40'd1000000000;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			send_event(DIRECTED[i].slot, DIRECTED[i].hash, DIRECTED[i].stamp,
				DIRECTED[i].typed, DIRECTED[i].want);
		end
		start_phase();
		random_events(200);

		for (int p = 0; p < NUM_SETTINGS; p++) begin
			in_valid <= 1'b0;
			wait_drained();
			repeat (2) @(posedge clk);
			cfg_write(REG_BURST_LINES, WINDOW_W'(SETTINGS_LIST[p].burst));
			cfg_write(REG_WINDOW_LENGTH, SETTINGS_LIST[p].window);
			start_phase();
			random_events(180);
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	// result word checker
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("result word with nothing expected, repeat %0d",
					repeat_count));
			end else begin
				want = pending_verdicts.pop_front();
				if (log_now !== want.log_now)
					report_mismatch($sformatf("log_now got %b want %b", log_now, want.log_now));
				if (drop_reason !== want.reason)
					report_mismatch($sformatf("drop_reason got %0d want %s",
						drop_reason, want.reason.name()));
				if (repeat_count !== want.repeats)
					report_mismatch($sformatf("repeat_count got %0d want %0d",
						repeat_count, want.repeats));
				if (flushed_count !== want.flushed)
					report_mismatch($sformatf("flushed_count got %0d want %0d",
						flushed_count, want.flushed));
			end
		end
	end

	// receiver stall pattern, switching style on the stall tick counter
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_tick = 0;
	int          hold_cnt   = 0;

	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 100 == 99) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
		end
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
			STALL_PERIODIC: out_stall <= (stall_tick % 4 == 3);
			default: begin
				if (hold_cnt == 0) begin
					hold_cnt  <= $urandom_range(0, 8);
					out_stall <= ~out_stall;
				end else begin
					hold_cnt <= hold_cnt - 1;
				end
			end
		endcase
	end

	// watchdog on cycles without any word moving
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[%0t] no word moved for %0d cycles", $realtime, IDLE_LIMIT);
			$display("testbench NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
